@@ hdl/triangle_raster_depth_buffer_assert.svh @@
// Assertion macros for the triangle raster depth buffer.
// Used by the top level only; needs a clock and an active-low reset name.
`ifndef TRIANGLE_RASTER_DEPTH_BUFFER_ASSERT_SVH
`define TRIANGLE_RASTER_DEPTH_BUFFER_ASSERT_SVH

// same-cycle implication
`define TRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trd assertion failed");

// next-cycle implication
`define TRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trd assertion failed");

`endif

@@ hdl/trd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the triangle raster depth buffer.
// No dependencies.
package trd_pkg;

    localparam int CW  = 11;     // coordinate width
    localparam int BW  = 12;     // clipped bound width, signed
    localparam int DW  = 16;     // depth width, Q8.8
    localparam int GW  = 8;      // glyph width
    localparam int KW  = 4;      // color width
    localparam int NW  = 12;     // cell count width
    localparam int EW  = 26;     // edge function width, signed
    localparam int SW  = 18;     // depth sum width
    localparam int RS  = 19;     // reciprocal shift for divide by three
    localparam int RW  = 18;     // reciprocal width

    localparam logic [RW-1:0] RECIP3      = 18'd174763;
    localparam logic [DW-1:0] DEPTH_FAR   = 16'hFFFF;
    localparam logic [GW-1:0] BLANK_GLYPH = 8'h20;
    localparam logic [KW-1:0] BLANK_COLOR = 4'd8;
    localparam logic [NW-1:0] COUNT_MAX   = 12'd4095;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_CLEAR,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_RESP
    } t_state;

    typedef logic signed [EW-1:0] t_edge;
    typedef logic signed [BW-1:0] t_step;

    typedef struct packed {
        logic [DW-1:0] depth;
        logic [GW-1:0] glyph;
        logic [KW-1:0] color;
    } t_cell;

    typedef struct packed {
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [DW-1:0] da;
        logic [DW-1:0] db;
        logic [DW-1:0] dc;
    } t_tri;

    typedef struct packed {
        logic          empty;
        logic [CW-1:0] lox;
        logic [CW-1:0] hix;
        logic [CW-1:0] loy;
        logic [CW-1:0] hiy;
        logic [DW-1:0] flat;
        t_edge [2:0]   e;
        t_step [2:0]   stx;
        t_step [2:0]   sty;
    } t_setup;

endpackage

@@ hdl/trd_cmd_if.sv @@
`timescale 1ns / 1ps
// Command channel: valid/ready plus the operation and triangle fields.
// Depends on trd_pkg.
interface trd_cmd_if import trd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [DW-1:0]        depth_a;
    logic [DW-1:0]        depth_b;
    logic [DW-1:0]        depth_c;
    logic [GW-1:0]        glyph;
    logic [KW-1:0]        color;

    modport source (
        output valid, operation, ax, ay, bx, by, cx, cy,
               depth_a, depth_b, depth_c, glyph, color,
        input  ready
    );
    modport sink (
        input  valid, operation, ax, ay, bx, by, cx, cy,
               depth_a, depth_b, depth_c, glyph, color,
        output ready
    );
endinterface

@@ hdl/trd_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready plus cell read data and written-cell count.
// Depends on trd_pkg.
interface trd_rsp_if import trd_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [GW-1:0] cell_glyph;
    logic [KW-1:0] cell_color;
    logic [NW-1:0] cells_written;

    modport source (output valid, cell_glyph, cell_color, cells_written, input ready);
    modport sink   (input valid, cell_glyph, cell_color, cells_written, output ready);
endinterface

@@ hdl/trd_frame_mem.sv @@
`timescale 1ns / 1ps
// Frame store: one write port, one read port, registered read data.
// Depends on trd_pkg for the cell type.
module trd_frame_mem import trd_pkg::*; #(
    parameter int DEPTH = 2700,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_cell         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_cell         o_rdata
);
    t_cell r_mem [DEPTH];
    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

@@ hdl/trd_tri_setup.sv @@
`timescale 1ns / 1ps
// Triangle setup: clipped bounding box, flat depth, edge functions at the
// box corner and their steps. Depends on trd_pkg.
module trd_tri_setup import trd_pkg::*; #(
    parameter int SCREEN_COLS = 90,
    parameter int SCREEN_ROWS = 30,
    parameter int AW          = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  t_tri          i_tri,
    output logic          o_done,
    output t_setup        o_setup,
    output logic [AW-1:0] o_start_addr
);
    localparam logic signed [BW-1:0] COLS_M1 = BW'(SCREEN_COLS - 1);
    localparam logic signed [BW-1:0] ROWS_M1 = BW'(SCREEN_ROWS - 1);

    logic r_v1, r_v2, r_v3;

    logic signed [BW-1:0] vx [3];
    logic signed [BW-1:0] vy [3];
    logic signed [BW-1:0] vxn [3];
    logic signed [BW-1:0] vyn [3];

    logic signed [BW-1:0] mnx, mxx, mny, mxy;
    logic signed [BW-1:0] r1_lox, r1_hix, r1_loy, r1_hiy;
    logic [SW-1:0]        r1_sum;

    t_edge                r2_pa [3];
    t_edge                r2_pb [3];
    logic [SW+RW-1:0]     r2_prod;
    logic                 r2_empty;
    logic [AW-1:0]        r2_start;
    logic [31:0]          start_w;

    t_setup               r_st;
    logic [AW-1:0]        r_start;

    function automatic logic signed [BW-1:0] min3(
        input logic signed [BW-1:0] a, input logic signed [BW-1:0] b,
        input logic signed [BW-1:0] c
    );
        logic signed [BW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [BW-1:0] max3(
        input logic signed [BW-1:0] a, input logic signed [BW-1:0] b,
        input logic signed [BW-1:0] c
    );
        logic signed [BW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    assign vx[0] = BW'($signed(i_tri.ax));
    assign vy[0] = BW'($signed(i_tri.ay));
    assign vx[1] = BW'($signed(i_tri.bx));
    assign vy[1] = BW'($signed(i_tri.by));
    assign vx[2] = BW'($signed(i_tri.cx));
    assign vy[2] = BW'($signed(i_tri.cy));
    assign vxn[0] = vx[1];
    assign vyn[0] = vy[1];
    assign vxn[1] = vx[2];
    assign vyn[1] = vy[2];
    assign vxn[2] = vx[0];
    assign vyn[2] = vy[0];

    assign mnx = min3(vx[0], vx[1], vx[2]);
    assign mxx = max3(vx[0], vx[1], vx[2]);
    assign mny = min3(vy[0], vy[1], vy[2]);
    assign mxy = max3(vy[0], vy[1], vy[2]);

    assign start_w = 32'(r1_loy[CW-1:0]) * 32'(SCREEN_COLS) + 32'(r1_lox[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: box, clip, depth sum
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r1_lox <= (mnx < 0) ? '0 : mnx;
            r1_hix <= (mxx > COLS_M1) ? COLS_M1 : mxx;
            r1_loy <= (mny < 0) ? '0 : mny;
            r1_hiy <= (mxy > ROWS_M1) ? ROWS_M1 : mxy;
            r1_sum <= SW'(i_tri.da) + SW'(i_tri.db) + SW'(i_tri.dc);
        end
    end

    // stage 2: corner products and reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int i = 0; i < 3; i++) begin
                r2_pa[i] <= EW'(r1_loy - vy[i]) * EW'(vx[i] - vxn[i]);
                r2_pb[i] <= EW'(r1_lox - vx[i]) * EW'(vy[i] - vyn[i]);
            end
            r2_prod  <= (SW+RW)'(r1_sum) * (SW+RW)'(RECIP3);
            r2_empty <= (r1_lox > r1_hix) || (r1_loy > r1_hiy);
            r2_start <= AW'(start_w);
        end
    end

    // stage 3: edge values at the corner, edge steps
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            for (int i = 0; i < 3; i++) begin
                r_st.e[i]   <= r2_pa[i] - r2_pb[i];
                r_st.stx[i] <= vyn[i] - vy[i];
                r_st.sty[i] <= vx[i] - vxn[i];
            end
            r_st.flat  <= r2_prod[RS +: DW];
            r_st.empty <= r2_empty;
            r_st.lox   <= r1_lox[CW-1:0];
            r_st.hix   <= r1_hix[CW-1:0];
            r_st.loy   <= r1_loy[CW-1:0];
            r_st.hiy   <= r1_hiy[CW-1:0];
            r_start    <= r2_start;
        end
    end

    assign o_done       = r_v3;
    assign o_setup      = r_st;
    assign o_start_addr = r_start;
endmodule

@@ hdl/triangle_raster_depth_buffer.sv @@
`timescale 1ns / 1ps
// Top level: command decode, clear sweep, raster scan with depth test.
// Depends on trd_pkg, trd_cmd_if, trd_rsp_if, trd_frame_mem, trd_tri_setup.
//
//  port     dir  kind        beat contents
//  i_cmd    in   valid/ready operation, vertices, depths, glyph, color
//  o_rsp    out  valid/ready cell_glyph, cell_color, cells_written
//
// Clear: one cell per cycle through the frame store.
// Draw: setup, then one clipped-box cell per cycle, then drain; an empty box skips both.
// Read: store read, result. Unused code: result. Store read and write ports set the pace.
// After reset a sweep over all COLS*ROWS cells blanks the frame; i_cmd.ready is low.
// One command at a time; the next is taken while a result waits on o_rsp.
module triangle_raster_depth_buffer import trd_pkg::*; #(
    parameter int SCREEN_COLS = 90,
    parameter int SCREEN_ROWS = 30
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    trd_cmd_if.sink   i_cmd,
    trd_rsp_if.source o_rsp
);
    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_COLS);
    localparam t_cell BLANK = '{depth: DEPTH_FAR, glyph: BLANK_GLYPH, color: BLANK_COLOR};

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [1:0]    r_op, n_op;
    t_tri          r_tri, n_tri;
    logic [GW-1:0] r_glyph, n_glyph;
    logic [KW-1:0] r_color, n_color;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_rd_ok, n_rd_ok;
    logic          r_go, n_go;

    logic [CW-1:0] r_x, n_x;
    logic [CW-1:0] r_y, n_y;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_row_addr, n_row_addr;
    t_edge         r_e [3];
    t_edge         n_e [3];
    t_edge         r_e_row [3];
    t_edge         n_e_row [3];

    logic          r_p_valid, n_p_valid;
    logic          r_p_inside, n_p_inside;
    logic [AW-1:0] r_p_addr, n_p_addr;
    logic [NW-1:0] r_count, n_count;

    logic          r_ovalid;
    logic [GW-1:0] r_oglyph;
    logic [KW-1:0] r_ocolor;
    logic [NW-1:0] r_ocount;
    logic          load_out;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_cell         mem_wdata, mem_q;

    logic          st_done;
    t_setup        st;
    logic [AW-1:0] st_start;

    logic          cmd_in_range;
    logic [31:0]   cmd_addr_w;

    trd_frame_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    trd_tri_setup #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .AW          (AW)
    ) u_setup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (r_go),
        .i_tri        (r_tri),
        .o_done       (st_done),
        .o_setup      (st),
        .o_start_addr (st_start)
    );

    assign cmd_in_range = !i_cmd.ax[CW-1] && !i_cmd.ay[CW-1]
                        && ({1'b0, i_cmd.ax} < BW'(SCREEN_COLS))
                        && ({1'b0, i_cmd.ay} < BW'(SCREEN_ROWS));
    assign cmd_addr_w = 32'(i_cmd.ay[CW-2:0]) * 32'(SCREEN_COLS) + 32'(i_cmd.ax[CW-2:0]);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_op       = r_op;
        n_tri      = r_tri;
        n_glyph    = r_glyph;
        n_color    = r_color;
        n_rd_addr  = r_rd_addr;
        n_rd_ok    = r_rd_ok;
        n_go       = 1'b0;
        n_x        = r_x;
        n_y        = r_y;
        n_addr     = r_addr;
        n_row_addr = r_row_addr;
        n_e        = r_e;
        n_e_row    = r_e_row;
        n_p_valid  = 1'b0;
        n_p_inside = 1'b0;
        n_p_addr   = r_addr;
        n_count    = r_count;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = BLANK;
        mem_re     = 1'b0;
        mem_raddr  = r_addr;
        i_cmd.ready = 1'b0;

        // depth test and write-back of the cell read last cycle
        if (r_p_valid && r_p_inside && (st.flat < mem_q.depth)) begin
            mem_we    = 1'b1;
            mem_waddr = r_p_addr;
            mem_wdata = '{depth: st.flat, glyph: r_glyph, color: r_color};
            if (r_count != COUNT_MAX) begin
                n_count = r_count + NW'(1);
            end
        end

        unique case (r_state)
            S_INIT_CLR, S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = BLANK;
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_state    = (r_state == S_INIT_CLR) ? S_IDLE : S_RESP;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_op      = i_cmd.operation;
                    n_tri     = '{ax: i_cmd.ax, ay: i_cmd.ay, bx: i_cmd.bx, by: i_cmd.by,
                                  cx: i_cmd.cx, cy: i_cmd.cy, da: i_cmd.depth_a,
                                  db: i_cmd.depth_b, dc: i_cmd.depth_c};
                    n_glyph   = i_cmd.glyph;
                    n_color   = i_cmd.color;
                    n_rd_addr = AW'(cmd_addr_w);
                    n_rd_ok   = cmd_in_range;
                    n_count   = '0;
                    unique case (t_op'(i_cmd.operation))
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_DRAW: begin
                            n_go    = 1'b1;
                            n_state = S_SETUP;
                        end
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_SETUP: begin
                if (st_done) begin
                    if (st.empty) begin
                        n_state = S_RESP;
                    end else begin
                        n_x        = st.lox;
                        n_y        = st.loy;
                        n_addr     = st_start;
                        n_row_addr = st_start;
                        for (int i = 0; i < 3; i++) begin
                            n_e[i]     = st.e[i];
                            n_e_row[i] = st.e[i];
                        end
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                mem_re     = 1'b1;
                mem_raddr  = r_addr;
                n_p_valid  = 1'b1;
                n_p_inside = !r_e[0][EW-1] && !r_e[1][EW-1] && !r_e[2][EW-1];
                n_p_addr   = r_addr;
                if (r_x == st.hix) begin
                    if (r_y == st.hiy) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_y        = r_y + CW'(1);
                        n_x        = st.lox;
                        n_row_addr = r_row_addr + ROW_STEP;
                        n_addr     = r_row_addr + ROW_STEP;
                        for (int i = 0; i < 3; i++) begin
                            n_e_row[i] = r_e_row[i] + EW'($signed(st.sty[i]));
                            n_e[i]     = r_e_row[i] + EW'($signed(st.sty[i]));
                        end
                    end
                end else begin
                    n_x    = r_x + CW'(1);
                    n_addr = r_addr + AW'(1);
                    for (int i = 0; i < 3; i++) begin
                        n_e[i] = r_e[i] + EW'($signed(st.stx[i]));
                    end
                end
            end
            S_DRAIN: n_state = S_RESP;
            S_READ: begin
                mem_re    = 1'b1;
                mem_raddr = r_rd_addr;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_go       <= 1'b0;
            r_p_valid  <= 1'b0;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_go       <= n_go;
            r_p_valid  <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_tri      <= n_tri;
        r_glyph    <= n_glyph;
        r_color    <= n_color;
        r_rd_addr  <= n_rd_addr;
        r_rd_ok    <= n_rd_ok;
        r_x        <= n_x;
        r_y        <= n_y;
        r_addr     <= n_addr;
        r_row_addr <= n_row_addr;
        r_e        <= n_e;
        r_e_row    <= n_e_row;
        r_p_inside <= n_p_inside;
        r_p_addr   <= n_p_addr;
        r_count    <= n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            unique case (t_op'(r_op))
                OP_READ: begin
                    r_oglyph <= r_rd_ok ? mem_q.glyph : '0;
                    r_ocolor <= r_rd_ok ? mem_q.color : '0;
                    r_ocount <= '0;
                end
                OP_DRAW: begin
                    r_oglyph <= '0;
                    r_ocolor <= '0;
                    r_ocount <= r_count;
                end
                default: begin
                    r_oglyph <= '0;
                    r_ocolor <= '0;
                    r_ocount <= '0;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.cell_glyph    = r_oglyph;
    assign o_rsp.cell_color    = r_ocolor;
    assign o_rsp.cells_written = r_ocount;

`include "triangle_raster_depth_buffer_assert.svh"

    `TRD_ASSERT_IMPL(a_wb_addr, i_clk, i_rst_n, mem_we && r_p_valid, mem_waddr == $past(mem_raddr))
    `TRD_ASSERT_IMPL(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN, 32'(r_addr) < CELLS)
    `TRD_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready)

endmodule

@@ sim/tb_triangle_raster_depth_buffer.sv @@
`timescale 1ns / 1ps
// Self-checking bench for triangle_raster_depth_buffer: directed and random clear/draw/read
// beats, a cell-accurate frame and depth predictor, and an in-order result check.
// Depends on trd_pkg, trd_cmd_if, trd_rsp_if and the block itself.
module tb_triangle_raster_depth_buffer;
    import trd_pkg::*;

    localparam int COLS        = 90;
    localparam int ROWS        = 30;
    localparam int CELLS       = COLS * ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_LEN   = 30;
    localparam int TAIL_CYCLES = 64;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [DW-1:0]        da;
        logic [DW-1:0]        db;
        logic [DW-1:0]        dc;
        logic [GW-1:0]        glyph;
        logic [KW-1:0]        color;
        bit                   hold;
    } t_cmd_item;

    typedef struct packed {
        logic [GW-1:0] glyph;
        logic [KW-1:0] color;
        logic [NW-1:0] count;
    } t_cell_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    trd_cmd_if cmd_bus();
    trd_rsp_if rsp_bus();

    triangle_raster_depth_buffer #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_rsp  (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    logic [DW-1:0] frame_depth [CELLS];
    logic [GW-1:0] frame_glyph [CELLS];
    logic [KW-1:0] frame_color [CELLS];

    t_cmd_item cmd_pending_q[$];
    t_cell_rsp rsp_expected_q[$];
    t_cmd_item cur_cmd;

    int sent_cnt = 0;
    int got_cnt = 0;
    int total_cmds = 0;
    int errors = 0;
    int n_clear = 0, n_draw = 0, n_read = 0, n_unused = 0, n_cells = 0;

    function automatic void frame_blank();
        for (int i = 0; i < CELLS; i++) begin
            frame_depth[i] = DEPTH_FAR;
            frame_glyph[i] = BLANK_GLYPH;
            frame_color[i] = BLANK_COLOR;
        end
    endfunction

    // apply one command to the shadow frame and return the result it must produce
    function automatic t_cell_rsp frame_apply(t_cmd_item c);
        t_cell_rsp r;
        int x1, y1, x2, y2, x3, y3, flat, lox, hix, loy, hiy, cnt, k;
        bit e1, e2, e3;
        r = '0;
        x1 = int'($signed(c.ax));
        y1 = int'($signed(c.ay));
        x2 = int'($signed(c.bx));
        y2 = int'($signed(c.by));
        x3 = int'($signed(c.cx));
        y3 = int'($signed(c.cy));
        case (c.op)
            OP_CLEAR: begin
                frame_blank();
                n_clear++;
            end
            OP_DRAW: begin
                flat = (int'(c.da) + int'(c.db) + int'(c.dc)) / 3;
                lox = (x1 < x2) ? x1 : x2;
                lox = (lox < x3) ? lox : x3;
                hix = (x1 > x2) ? x1 : x2;
                hix = (hix > x3) ? hix : x3;
                loy = (y1 < y2) ? y1 : y2;
                loy = (loy < y3) ? loy : y3;
                hiy = (y1 > y2) ? y1 : y2;
                hiy = (hiy > y3) ? hiy : y3;
                if (lox < 0) lox = 0;
                if (hix >= COLS) hix = COLS - 1;
                if (loy < 0) loy = 0;
                if (hiy >= ROWS) hiy = ROWS - 1;
                cnt = 0;
                for (int y = loy; y <= hiy; y++) begin
                    for (int x = lox; x <= hix; x++) begin
                        e1 = (y - y1) * (x1 - x2) >= (x - x1) * (y1 - y2);
                        e2 = (y - y2) * (x2 - x3) >= (x - x2) * (y2 - y3);
                        e3 = (y - y3) * (x3 - x1) >= (x - x3) * (y3 - y1);
                        if (e1 && e2 && e3) begin
                            k = y * COLS + x;
                            if (flat < int'(frame_depth[k])) begin
                                frame_depth[k] = flat[DW-1:0];
                                frame_glyph[k] = c.glyph;
                                frame_color[k] = c.color;
                                if (cnt < int'(COUNT_MAX)) cnt++;
                            end
                        end
                    end
                end
                r.count = cnt[NW-1:0];
                n_draw++;
                n_cells += cnt;
            end
            OP_READ: begin
                if (x1 >= 0 && x1 < COLS && y1 >= 0 && y1 < ROWS) begin
                    k = y1 * COLS + x1;
                    r.glyph = frame_glyph[k];
                    r.color = frame_color[k];
                end
                n_read++;
            end
            default: n_unused++;
        endcase
        return r;
    endfunction

    function automatic t_cmd_item cmd_make(logic [1:0] op, int ax, int ay, int bx, int by,
                                           int cx, int cy, int da, int db, int dc,
                                           int g, int col);
        t_cmd_item c;
        c.op    = op;
        c.ax    = ax[CW-1:0];
        c.ay    = ay[CW-1:0];
        c.bx    = bx[CW-1:0];
        c.by    = by[CW-1:0];
        c.cx    = cx[CW-1:0];
        c.cy    = cy[CW-1:0];
        c.da    = da[DW-1:0];
        c.db    = db[DW-1:0];
        c.dc    = dc[DW-1:0];
        c.glyph = g[GW-1:0];
        c.color = col[KW-1:0];
        c.hold  = 1'b0;
        return c;
    endfunction

    // draw with vertices b and c ordered so the block's accepted winding holds
    function automatic t_cmd_item tri_facing(int ax, int ay, int bx, int by, int cx, int cy,
                                             int da, int db, int dc, int g, int col);
        if ((bx - ax) * (cy - ay) - (by - ay) * (cx - ax) > 0)
            return cmd_make(OP_DRAW, ax, ay, cx, cy, bx, by, da, dc, db, g, col);
        return cmd_make(OP_DRAW, ax, ay, bx, by, cx, cy, da, db, dc, g, col);
    endfunction

    function automatic t_cmd_item read_at(int x, int y);
        return cmd_make(OP_READ, x, y, int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom));
    endfunction

    function automatic int depth_pick();
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535));
        return int'($urandom_range(0, 16'h7FFF));
    endfunction

    function automatic int send_idle_pct(int n);
        case ((n / PHASE_LEN) % 4)
            1: return 53;
            3: return 26;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(int n);
        case ((n / PHASE_LEN) % 4)
            2: return 53;
            3: return 26;
            default: return 0;
        endcase
    endfunction

    // driver: one beat in flight, next item presented on the take unless gapped or held
    always @(posedge i_clk) begin : drv
        bit acc;
        int issued;
        if (!i_rst_n) begin
            frame_blank();
            cmd_bus.valid     <= 1'b0;
            cmd_bus.operation <= '0;
            cmd_bus.ax        <= '0;
            cmd_bus.ay        <= '0;
            cmd_bus.bx        <= '0;
            cmd_bus.by        <= '0;
            cmd_bus.cx        <= '0;
            cmd_bus.cy        <= '0;
            cmd_bus.depth_a   <= '0;
            cmd_bus.depth_b   <= '0;
            cmd_bus.depth_c   <= '0;
            cmd_bus.glyph     <= '0;
            cmd_bus.color     <= '0;
        end else begin
            acc = cmd_bus.valid && cmd_bus.ready;
            issued = sent_cnt + (acc ? 1 : 0);
            if (acc) begin
                rsp_expected_q.push_back(frame_apply(cur_cmd));
                sent_cnt <= issued;
            end
            if (!cmd_bus.valid || acc) begin
                if (cmd_pending_q.size() != 0
                        && $urandom_range(0, 99) >= send_idle_pct(issued)
                        && (!cmd_pending_q[0].hold || issued == got_cnt)) begin
                    cur_cmd = cmd_pending_q.pop_front();
                    cmd_bus.operation <= cur_cmd.op;
                    cmd_bus.ax        <= cur_cmd.ax;
                    cmd_bus.ay        <= cur_cmd.ay;
                    cmd_bus.bx        <= cur_cmd.bx;
                    cmd_bus.by        <= cur_cmd.by;
                    cmd_bus.cx        <= cur_cmd.cx;
                    cmd_bus.cy        <= cur_cmd.cy;
                    cmd_bus.depth_a   <= cur_cmd.da;
                    cmd_bus.depth_b   <= cur_cmd.db;
                    cmd_bus.depth_c   <= cur_cmd.dc;
                    cmd_bus.glyph     <= cur_cmd.glyph;
                    cmd_bus.color     <= cur_cmd.color;
                    cmd_bus.valid     <= 1'b1;
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : mon
        t_cell_rsp want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got_cnt <= got_cnt + 1;
                if (rsp_expected_q.size() == 0) begin
                    $display("%0t unexpected result: glyph %0h color %0h count %0d", $time,
                             rsp_bus.cell_glyph, rsp_bus.cell_color, rsp_bus.cells_written);
                    errors++;
                end else begin
                    want = rsp_expected_q.pop_front();
                    if (rsp_bus.cell_glyph !== want.glyph) begin
                        $display("%0t cell_glyph: expected %0h actual %0h", $time,
                                 want.glyph, rsp_bus.cell_glyph);
                        errors++;
                    end
                    if (rsp_bus.cell_color !== want.color) begin
                        $display("%0t cell_color: expected %0h actual %0h", $time,
                                 want.color, rsp_bus.cell_color);
                        errors++;
                    end
                    if (rsp_bus.cells_written !== want.count) begin
                        $display("%0t cells_written: expected %0d actual %0d", $time,
                                 want.count, rsp_bus.cells_written);
                        errors++;
                    end
                end
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct(sent_cnt));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main
        t_cmd_item c;
        int r, ox, oy, span;
        i_rst_n = 1'b0;

        // reset contents, screen corners and off-screen reads
        cmd_pending_q.push_back(read_at(0, 0));
        cmd_pending_q.push_back(read_at(COLS - 1, ROWS - 1));
        cmd_pending_q.push_back(read_at(COLS, 0));
        cmd_pending_q.push_back(read_at(0, ROWS));
        cmd_pending_q.push_back(read_at(-1, -1));
        cmd_pending_q.push_back(read_at(-1024, 1023));
        // two halves covering the whole screen, vertices at the coordinate extremes
        cmd_pending_q.push_back(cmd_make(OP_DRAW, -1024, -1024, 1023, 1023, 1023, -1024,
                                         16'h0100, 16'h0100, 16'h0100, 8'hFF, 15));
        cmd_pending_q.push_back(cmd_make(OP_DRAW, -1024, -1024, -1024, 1023, 1023, 1023,
                                         0, 0, 0, 0, 0));
        cmd_pending_q.push_back(read_at(COLS - 1, 0));
        cmd_pending_q.push_back(read_at(0, ROWS - 1));
        cmd_pending_q.push_back(cmd_make(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_pending_q.push_back(read_at(45, 15));
        // farthest flat depth never beats a cleared cell
        cmd_pending_q.push_back(tri_facing(10, 5, 20, 5, 10, 12, 16'hFFFF, 16'hFFFF,
                                           16'hFFFF, 8'h55, 5));
        // wrong winding, then the same triangle facing the right way
        cmd_pending_q.push_back(cmd_make(OP_DRAW, 10, 5, 20, 5, 10, 12, 16'h0200,
                                         16'h0200, 16'h0200, 8'h23, 2));
        cmd_pending_q.push_back(cmd_make(OP_DRAW, 10, 5, 10, 12, 20, 5, 16'h1234,
                                         16'hFFFF, 16'h0001, 8'h41, 3));
        // degenerate: a single point, then three vertices that are not quite collinear
        cmd_pending_q.push_back(cmd_make(OP_DRAW, 30, 10, 30, 10, 30, 10, 16'h0010,
                                         16'h0010, 16'h0010, 8'h2A, 9));
        cmd_pending_q.push_back(cmd_make(OP_DRAW, 0, 0, 40, 20, 80, 29, 16'h0008,
                                         16'h0008, 16'h0008, 8'h2D, 12));
        // bounding box entirely off screen
        cmd_pending_q.push_back(tri_facing(-50, 5, -10, 5, -30, 20, 0, 0, 0, 8'h58, 1));
        cmd_pending_q.push_back(tri_facing(200, 0, 300, 10, 250, 500, 0, 0, 0, 8'h59, 1));
        cmd_pending_q.push_back(read_at(15, 6));
        cmd_pending_q.push_back(read_at(30, 10));
        cmd_pending_q.push_back(cmd_make(OP_UNUSED, -1, -1, -1, -1, -1, -1, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 8'hFF, 15));
        cmd_pending_q.push_back(cmd_make(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_pending_q.push_back(cmd_make(OP_CLEAR, -1, -1, -1, -1, -1, -1, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 8'hFF, 15));
        cmd_pending_q.push_back(read_at(10, 5));

        for (int n = 0; n < 200; n++) begin
            r = int'($urandom_range(0, 99));
            if (r < 4) begin
                c = cmd_make(OP_CLEAR, int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end else if (r < 50) begin
                ox = int'($urandom_range(0, COLS + 9)) - 5;
                oy = int'($urandom_range(0, ROWS + 9)) - 5;
                span = ($urandom_range(0, 9) == 0) ? 60 : 8;
                c = tri_facing(ox + int'($urandom_range(0, span)) - span / 2,
                               oy + int'($urandom_range(0, span)) - span / 2,
                               ox + int'($urandom_range(0, span)) - span / 2,
                               oy + int'($urandom_range(0, span)) - span / 2,
                               ox + int'($urandom_range(0, span)) - span / 2,
                               oy + int'($urandom_range(0, span)) - span / 2,
                               depth_pick(), depth_pick(), depth_pick(),
                               int'($urandom), int'($urandom));
            end else if (r < 60) begin
                c = cmd_make(OP_DRAW, int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end else if (r < 92) begin
                if ($urandom_range(0, 4) == 0)
                    c = read_at(int'($urandom), int'($urandom));
                else
                    c = read_at(int'($urandom_range(0, COLS - 1)),
                                int'($urandom_range(0, ROWS - 1)));
            end else begin
                c = cmd_make(OP_UNUSED, int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end
            // let the pipeline drain completely before a couple of beats
            c.hold = (n == 0) || (n == 130);
            cmd_pending_q.push_back(c);
        end
        total_cmds = cmd_pending_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt != total_cmds || got_cnt != total_cmds) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (rsp_expected_q.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, rsp_expected_q.size());
            errors++;
        end
        $display("Ran %0d clears, %0d draws (%0d cells written), %0d reads, %0d unused codes,",
                 n_clear, n_draw, n_cells, n_read, n_unused);
        $display("cycling no-gap, sender-gap, receiver-stall and mixed back-pressure phases.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/trd_pkg.sv
hdl/trd_cmd_if.sv
hdl/trd_rsp_if.sv
hdl/trd_frame_mem.sv
hdl/trd_tri_setup.sv
hdl/triangle_raster_depth_buffer.sv
sim/tb_triangle_raster_depth_buffer.sv
